>>> src/c2s_pkg.sv
// Package for the Cartesian to spherical converter: word types, widths and constants.
// Holds the arctangent table and the CORDIC gain constant. It depends on nothing else.
package c2s_pkg;

	localparam int COORD_BITS = 24;
	localparam int FRAC_BITS  = 8;
	localparam int DATA_W     = COORD_BITS + FRAC_BITS + 3;
	localparam int ANGLE_W    = 32;
	localparam int OUT_W      = 24;
	localparam int ATAN_DEPTH = 32;

	localparam logic [31:0] GAIN_Q32 = 32'd2608131497;
	localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;
	localparam logic signed [OUT_W-1:0] LAT_MAX = 24'sd4194304;
	localparam logic signed [OUT_W-1:0] LAT_MIN = -24'sd4194304;

	localparam logic [ANGLE_W-1:0] ATAN_TAB [ATAN_DEPTH] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x_coord;
		logic signed [COORD_BITS-1:0] y_coord;
		logic signed [COORD_BITS-1:0] z_coord;
	} point_t;

	typedef struct packed {
		logic        [OUT_W-1:0] radius;
		logic signed [OUT_W-1:0] longitude;
		logic signed [OUT_W-1:0] latitude;
		logic                    zero_radius;
	} result_t;

	typedef struct packed {
		logic                         three_d;
		logic                         zero_pt;
		logic                         vertical;
		logic signed [COORD_BITS-1:0] y_coord;
		logic        [ANGLE_W-1:0]    ang1;
		logic signed [DATA_W-1:0]     mag1;
	} side_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  a;
		logic signed [DATA_W-1:0]  b;
		logic        [ANGLE_W-1:0] ang;
		side_t                     side;
	} stage_t;

endpackage

>>> src/cartesian_to_spherical_convert.sv
// Top level of the Cartesian to spherical converter: entry stage, two CORDIC cell
// chains with gain stages, result formatting and the output register with skid word.
// Depends on c2s_pkg, c2s_cordic_cell and c2s_gain.
//
// Usage: a point word (x, y, z) enters on point_valid/point_ready and one result word
// (radius, longitude, latitude, zero_radius) leaves on result_valid/result_ready.
// mode_we with mode_wdata writes the mode bit: 1 gives 3D spherical output, 0 gives
// 2D polar output from x and y. Write it only while no word is in flight.
// Throughput is one point per clock while point_ready is high. The entry register
// loads at the accepting edge, then two chains of CORDIC_STAGES cells, two stages per
// gain multiplier and the output register follow before result_valid rises.
// A result waiting in the output register does not stop the pipeline; when it is
// stalled and a second result arrives, that word goes to a skid register and only
// then point_ready drops, freezing every cell until the receiver takes a word.
// Reset empties the pipeline and output, and sets the mode bit to 3D.
module cartesian_to_spherical_convert import c2s_pkg::*; #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    mode_we,
	input  logic    mode_wdata,
	input  logic    point_valid,
	output logic    point_ready,
	input  point_t  point,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int RAD_W = DATA_W + 1;
	localparam logic [ANGLE_W-1:0] ROUND_ANG = ANGLE_W'(1) << (ANGLE_W - OUT_W - 1);
	localparam logic [RAD_W-1:0]   ROUND_RAD = RAD_W'(1) << (FRAC_BITS - 1);

	logic                     mode_q;
	logic                     en;
	logic                     take_in;
	logic signed [DATA_W-1:0] x_sc;
	logic signed [DATA_W-1:0] y_sc;
	logic signed [DATA_W-1:0] z_sc;
	logic signed [DATA_W-1:0] b_raw;
	logic                     x_zero;
	logic                     y_zero;
	logic                     z_zero;
	logic                     x_neg;
	stage_t                   entry_c;
	stage_t                   entry_s1;
	logic                     entry_valid_s1;

	stage_t                   u1 [0:CORDIC_STAGES];
	logic [CORDIC_STAGES:0]   u1_v;
	stage_t                   g1;
	logic                     g1_v;
	stage_t                   u2_in;
	stage_t                   u2 [0:CORDIC_STAGES];
	logic [CORDIC_STAGES:0]   u2_v;
	stage_t                   g2;
	logic                     g2_v;

	logic [ANGLE_W-1:0]       lon_rnd;
	logic [ANGLE_W-1:0]       lat_rnd;
	logic signed [OUT_W-1:0]  lat_raw;
	logic signed [OUT_W-1:0]  lat_clamp;
	logic signed [DATA_W-1:0] y_ext;
	logic signed [DATA_W-1:0] y_abs;
	logic signed [DATA_W-1:0] mag_sel;
	logic [RAD_W-1:0]         rad_sum;
	logic [RAD_W-FRAC_BITS-1:0] rad_int;
	logic [OUT_W-1:0]         rad_val;
	result_t                  res_c;

	result_t                  res_q;
	logic                     res_valid_q;
	result_t                  skid_q;
	logic                     skid_valid_q;
	logic                     load_res;
	logic                     load_skid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	assign en          = !skid_valid_q;
	assign point_ready = en;
	assign take_in     = point_valid && point_ready;

	always_comb begin
		x_sc   = DATA_W'(point.x_coord) <<< FRAC_BITS;
		y_sc   = DATA_W'(point.y_coord) <<< FRAC_BITS;
		z_sc   = DATA_W'(point.z_coord) <<< FRAC_BITS;
		x_zero = point.x_coord == '0;
		y_zero = point.y_coord == '0;
		z_zero = point.z_coord == '0;
		x_neg  = point.x_coord[COORD_BITS-1];
		b_raw  = mode_q ? -z_sc : y_sc;

		entry_c.a             = x_neg ? -x_sc : x_sc;
		entry_c.b             = x_neg ? -b_raw : b_raw;
		entry_c.ang           = x_neg ? HALF_TURN : '0;
		entry_c.side.three_d  = mode_q;
		entry_c.side.zero_pt  = mode_q ? (x_zero && y_zero && z_zero) : (x_zero && y_zero);
		entry_c.side.vertical = mode_q && x_zero && z_zero && !y_zero;
		entry_c.side.y_coord  = point.y_coord;
		entry_c.side.ang1     = '0;
		entry_c.side.mag1     = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_s1 <= 1'b0;
		end else if (en) begin
			entry_valid_s1 <= take_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			entry_s1 <= entry_c;
		end
	end

	assign u1[0]   = entry_s1;
	assign u1_v[0] = entry_valid_s1;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_unit1
		c2s_cordic_cell #(.STAGE(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.src_valid (u1_v[i]),
			.src       (u1[i]),
			.dst_valid (u1_v[i+1]),
			.dst       (u1[i+1])
		);
	end

	c2s_gain u_gain1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (u1_v[CORDIC_STAGES]),
		.src       (u1[CORDIC_STAGES]),
		.dst_valid (g1_v),
		.dst       (g1)
	);

	always_comb begin
		u2_in           = g1;
		u2_in.b         = DATA_W'(g1.side.y_coord) <<< FRAC_BITS;
		u2_in.ang       = '0;
		u2_in.side.ang1 = g1.ang;
		u2_in.side.mag1 = g1.a;
	end

	assign u2[0]   = u2_in;
	assign u2_v[0] = g1_v;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_unit2
		c2s_cordic_cell #(.STAGE(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.src_valid (u2_v[i]),
			.src       (u2[i]),
			.dst_valid (u2_v[i+1]),
			.dst       (u2[i+1])
		);
	end

	c2s_gain u_gain2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (u2_v[CORDIC_STAGES]),
		.src       (u2[CORDIC_STAGES]),
		.dst_valid (g2_v),
		.dst       (g2)
	);

	always_comb begin
		lon_rnd = g2.side.ang1 + ROUND_ANG;
		lat_rnd = g2.ang + ROUND_ANG;
		lat_raw = signed'(lat_rnd[ANGLE_W-1 -: OUT_W]);
		if (lat_raw > LAT_MAX) begin
			lat_clamp = LAT_MAX;
		end else if (lat_raw < LAT_MIN) begin
			lat_clamp = LAT_MIN;
		end else begin
			lat_clamp = lat_raw;
		end

		y_ext = DATA_W'(g2.side.y_coord);
		y_abs = g2.side.y_coord[COORD_BITS-1] ? -y_ext : y_ext;
		if (g2.side.vertical) begin
			mag_sel = y_abs <<< FRAC_BITS;
		end else if (g2.side.three_d) begin
			mag_sel = g2.a;
		end else begin
			mag_sel = g2.side.mag1;
		end
		rad_sum = {1'b0, mag_sel} + ROUND_RAD;
		rad_int = rad_sum[RAD_W-1:FRAC_BITS];
		rad_val = (|rad_int[RAD_W-FRAC_BITS-1:OUT_W]) ? '1 : rad_int[OUT_W-1:0];

		res_c.zero_radius = 1'b0;
		res_c.radius      = rad_val;
		res_c.longitude   = signed'(lon_rnd[ANGLE_W-1 -: OUT_W]);
		res_c.latitude    = '0;
		if (g2.side.zero_pt) begin
			res_c.zero_radius = 1'b1;
			res_c.radius      = '0;
			res_c.longitude   = '0;
		end else if (g2.side.vertical) begin
			res_c.longitude = '0;
			res_c.latitude  = g2.side.y_coord[COORD_BITS-1] ? LAT_MIN : LAT_MAX;
		end else if (g2.side.three_d) begin
			res_c.latitude = lat_clamp;
		end
	end

	// The skid word refills the output register while the pipeline is frozen.
	assign load_res  = en ? (g2_v && (!res_valid_q || result_ready)) : result_ready;
	assign load_skid = en && g2_v && res_valid_q && !result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			if (load_skid) begin
				skid_valid_q <= 1'b1;
			end else if (result_ready) begin
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q <= en ? res_c : skid_q;
		end
		if (load_skid) begin
			skid_q <= res_c;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("skid word held while output register is empty");

	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(res_valid_q && !result_ready))
		else $error("skid register filled without a stalled output word");

	a_zero_angles: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.zero_radius) |->
		(result.radius == '0 && result.longitude == '0 && result.latitude == '0))
		else $error("origin result carries nonzero fields");

	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.latitude <= LAT_MAX && result.latitude >= LAT_MIN))
		else $error("latitude outside quarter turn");

endmodule

>>> src/c2s_cordic_cell.sv
// One CORDIC vectoring micro-rotation cell with its pipeline register.
// Uses the stage word type and the arctangent table from c2s_pkg.
module c2s_cordic_cell import c2s_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   src_valid,
	input  stage_t src,
	output logic   dst_valid,
	output stage_t dst
);

	logic signed [DATA_W-1:0] sa;
	logic signed [DATA_W-1:0] sb;
	stage_t                   nxt;
	logic                     valid_s1;
	stage_t                   data_s1;

	assign sa = src.a >>> STAGE;
	assign sb = src.b >>> STAGE;

	always_comb begin
		nxt = src;
		if (!src.b[DATA_W-1]) begin
			nxt.a   = src.a + sb;
			nxt.b   = src.b - sa;
			nxt.ang = src.ang + ATAN_TAB[STAGE];
		end else begin
			nxt.a   = src.a - sb;
			nxt.b   = src.b + sa;
			nxt.ang = src.ang - ATAN_TAB[STAGE];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign dst_valid = valid_s1;
	assign dst       = data_s1;

endmodule

>>> src/c2s_gain.sv
// Two-stage CORDIC gain compensation: the magnitude times the gain constant, floored.
// Uses the stage word type and the gain constant from c2s_pkg.
module c2s_gain import c2s_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   src_valid,
	input  stage_t src,
	output logic   dst_valid,
	output stage_t dst
);

	localparam int SPLIT_W = $bits(GAIN_Q32);
	localparam int HI_W    = DATA_W - 1 - SPLIT_W;

	logic [2*SPLIT_W-1:0]    lo_prod_s1;
	logic [HI_W-1:0]         hi_s1;
	logic                    neg_s1;
	stage_t                  hold_s1;
	logic                    valid_s1;
	logic [HI_W+SPLIT_W-1:0] hi_prod;
	logic [DATA_W-1:0]       mag_sum;
	stage_t                  nxt;
	stage_t                  data_s2;
	logic                    valid_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_prod_s1 <= src.a[SPLIT_W-1:0] * GAIN_Q32;
			hi_s1      <= src.a[DATA_W-2:SPLIT_W];
			neg_s1     <= src.a[DATA_W-1];
			hold_s1    <= src;
		end
	end

	always_comb begin
		hi_prod = hi_s1 * GAIN_Q32;
		mag_sum = DATA_W'(hi_prod) + DATA_W'(lo_prod_s1[2*SPLIT_W-1:SPLIT_W]);
		nxt     = hold_s1;
		nxt.a   = neg_s1 ? '0 : signed'(mag_sum);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= src_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign dst_valid = valid_s2;
	assign dst       = data_s2;

endmodule

>>> tb/c2s_monitor.sv
// Monitor for the Cartesian to spherical converter: watches the point, result and mode ports,
// predicts each result word with its own CORDIC model and compares it field by field.
// Depends on c2s_pkg for the word types, the arctangent table and the gain constant.
module c2s_monitor import c2s_pkg::*; #(
	parameter int STAGES = 24
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    mode_we,
	input  logic    mode_wdata,
	input  logic    point_valid,
	input  logic    point_ready,
	input  point_t  point,
	input  logic    result_valid,
	input  logic    result_ready,
	input  result_t result,
	output int      miscompares,
	output int      in_flight
);

	result_t spherical_due[$];
	result_t want;
	bit three_d = 1'b1;

	function automatic void cordic_vectoring(input longint a_in, input longint b_in,
		output longint mag, output bit [31:0] ang);
		longint a, b, sa, sb;
		bit [63:0] ua, hi_p, lo_p;
		a = a_in;
		b = b_in;
		ang = '0;
		if (a < 0) begin
			a = -a;
			b = -b;
			ang = HALF_TURN;
		end
		for (int i = 0; i < STAGES && i < ATAN_DEPTH; i++) begin
			sa = a >>> i;
			sb = b >>> i;
			if (b >= 0) begin
				a = a + sb;
				b = b - sa;
				ang = ang + ATAN_TAB[i];
			end else begin
				a = a - sb;
				b = b + sa;
				ang = ang - ATAN_TAB[i];
			end
		end
		if (a < 0) begin
			mag = 0;
		end else begin
			ua = a;
			hi_p = (ua >> 32) * 64'(GAIN_Q32);
			lo_p = (ua & 64'hFFFF_FFFF) * 64'(GAIN_Q32);
			mag = longint'(hi_p + (lo_p >> 32));
		end
	endfunction

	function automatic logic [OUT_W-1:0] round_angle(input bit [31:0] ang);
		bit [31:0] t;
		t = ang + 32'd128;
		return t[31:8];
	endfunction

	function automatic logic [OUT_W-1:0] round_radius(input longint mag);
		longint r;
		if (mag < 0)
			return '0;
		r = (mag + 128) >>> 8;
		return (r > 64'hFF_FFFF) ? 24'hFF_FFFF : r[OUT_W-1:0];
	endfunction

	function automatic result_t to_spherical(input point_t p, input bit sph);
		longint x, y, z, m1, m2, lat_s;
		bit [31:0] a1, a2;
		logic signed [OUT_W-1:0] lat24;
		result_t r;
		x = longint'(p.x_coord);
		y = longint'(p.y_coord);
		z = longint'(p.z_coord);
		r = '0;
		if (sph) begin
			if (x == 0 && y == 0 && z == 0) begin
				r.zero_radius = 1'b1;
			end else if (x == 0 && z == 0) begin
				r.latitude = (y > 0) ? LAT_MAX : LAT_MIN;
				r.radius = round_radius(((y > 0) ? y : -y) * 256);
			end else begin
				cordic_vectoring(x * 256, -z * 256, m1, a1);
				cordic_vectoring(m1, y * 256, m2, a2);
				r.longitude = round_angle(a1);
				lat24 = round_angle(a2);
				lat_s = lat24;
				if (lat_s > LAT_MAX)
					lat_s = LAT_MAX;
				if (lat_s < LAT_MIN)
					lat_s = LAT_MIN;
				r.latitude = lat_s[OUT_W-1:0];
				r.radius = round_radius(m2);
			end
		end else begin
			if (x == 0 && y == 0) begin
				r.zero_radius = 1'b1;
			end else begin
				cordic_vectoring(x * 256, y * 256, m1, a1);
				r.longitude = round_angle(a1);
				r.radius = round_radius(m1);
			end
		end
		return r;
	endfunction

	task automatic report(input string field, input longint exp_v, input longint got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
			miscompares++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spherical_due.delete();
			three_d = 1'b1;
			in_flight = 0;
		end else begin
			if (point_valid && point_ready)
				spherical_due.push_back(to_spherical(point, three_d));
			if (result_valid && result_ready) begin
				if (spherical_due.size() == 0) begin
					$display("%0t: result word with no point waiting, actual %h", $time, result);
					miscompares++;
				end else begin
					want = spherical_due.pop_front();
					report("radius", want.radius, result.radius);
					report("longitude", want.longitude, result.longitude);
					report("latitude", want.latitude, result.latitude);
					report("zero_radius", want.zero_radius, result.zero_radius);
				end
			end
			if (mode_we)
				three_d = mode_wdata;
			in_flight = spherical_due.size();
		end
	end

endmodule

>>> tb/tb.sv
// Testbench top for the Cartesian to spherical converter: clock, reset, point stimulus,
// random receiver stalls, mode writes and the verdict. Depends on c2s_pkg,
// cartesian_to_spherical_convert and c2s_monitor, which does all result checking.
module tb;
	import c2s_pkg::*;

	localparam int STAGES = 24;
	localparam int DRAIN_CYCLES = 2 * STAGES + 16;
	localparam int HOLD_CYCLES = 200;
	localparam int QUIET_LIMIT = 5000;
	localparam int RANDOM_PER_PHASE = 210;

	logic clk = 1'b0;
	logic arst_n;
	logic mode_we;
	logic mode_wdata;
	logic point_valid;
	logic point_ready;
	point_t point;
	logic result_valid;
	logic result_ready;
	result_t result;

	int miscompares;
	int in_flight;
	int send_idle;
	int recv_idle;
	int quiet_cycles;
	bit hold_req;
	bit hold_done;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	cartesian_to_spherical_convert #(
		.CORDIC_STAGES(STAGES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.mode_we(mode_we),
		.mode_wdata(mode_wdata),
		.point_valid(point_valid),
		.point_ready(point_ready),
		.point(point),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	c2s_monitor #(
		.STAGES(STAGES)
	) u_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.mode_we(mode_we),
		.mode_wdata(mode_wdata),
		.point_valid(point_valid),
		.point_ready(point_ready),
		.point(point),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.miscompares(miscompares),
		.in_flight(in_flight)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((point_valid && point_ready) || (result_valid && result_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// The receiver stalls at random, or for one long stretch when asked to.
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				result_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	function automatic point_t pt(input int x, input int y, input int z);
		point_t p;
		p.x_coord = x[COORD_BITS-1:0];
		p.y_coord = y[COORD_BITS-1:0];
		p.z_coord = z[COORD_BITS-1:0];
		return p;
	endfunction

	function automatic int extreme_coord();
		case ($urandom_range(4))
			0: return -8388608;
			1: return 8388607;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	function automatic point_t random_point();
		point_t p;
		case ($urandom_range(5))
			3: begin
				p = pt($urandom_range(8) - 4, $urandom_range(8) - 4, $urandom_range(8) - 4);
			end
			4: begin
				p = pt($urandom, $urandom, $urandom);
				if ($urandom_range(1))
					p.x_coord = '0;
				if ($urandom_range(1))
					p.y_coord = '0;
				if ($urandom_range(1))
					p.z_coord = '0;
			end
			5: begin
				p = pt(extreme_coord(), extreme_coord(), extreme_coord());
			end
			default: begin
				p = pt($urandom, $urandom, $urandom);
			end
		endcase
		return p;
	endfunction

	task automatic send_point(input point_t p);
		while ($urandom_range(99) < send_idle) begin
			point_valid <= 1'b0;
			@(negedge clk);
		end
		point_valid <= 1'b1;
		point <= p;
		@(posedge clk);
		while (!point_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Mode writes happen only once every word in flight has come out.
	task automatic start_phase(input bit sph, input int s_idle, input int r_idle);
		point_valid <= 1'b0;
		while (in_flight != 0)
			@(negedge clk);
		@(posedge clk);
		send_idle = s_idle;
		recv_idle = r_idle;
		@(negedge clk);
		mode_we <= 1'b1;
		mode_wdata <= sph;
		@(negedge clk);
		mode_we <= 1'b0;
	endtask

	task automatic random_phase(input bit with_hold);
		for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
			if (with_hold && n == 60) begin
				point_valid <= 1'b0;
				@(posedge clk);
				hold_req = 1'b1;
				@(negedge clk);
			end
			send_point(random_point());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		mode_we = 1'b0;
		mode_wdata = 1'b0;
		point_valid = 1'b0;
		point = '0;
		send_idle = 0;
		recv_idle = 0;
		hold_req = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		start_phase(1'b1, 10, 59);
		send_point(pt(0, 0, 0));
		send_point(pt(0, 5, 0));
		send_point(pt(0, -8388608, 0));
		send_point(pt(0, 8388607, 0));
		send_point(pt(8388607, 8388607, 8388607));
		send_point(pt(-8388608, -8388608, -8388608));
		send_point(pt(-8388608, 0, 0));
		send_point(pt(-1, 0, 0));
		send_point(pt(1, 0, 0));
		send_point(pt(0, 0, 1));
		send_point(pt(0, 0, -8388608));
		send_point(pt(3, -4, 12));
		send_point(pt(-8388608, 8388607, 0));

		start_phase(1'b0, 10, 59);
		send_point(pt(0, 0, 12345));
		send_point(pt(-8388608, 0, -1));
		send_point(pt(8388607, 8388607, 0));
		send_point(pt(-8388608, -8388608, 8388607));
		send_point(pt(0, -8388608, 0));
		send_point(pt(1, 1, 0));
		send_point(pt(-5, 0, 0));

		start_phase(1'b1, 10, 59);
		random_phase(1'b0);
		start_phase(1'b0, 59, 10);
		random_phase(1'b0);
		start_phase(1'b1, 0, 0);
		random_phase(1'b1);

		point_valid <= 1'b0;
		while (in_flight != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (miscompares == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
